// ----- design/skf_pkg.sv -----
package skf_pkg;

  // field widths
  localparam int unsigned DW = 32;   // Q16.16 data
  localparam int unsigned GW = 17;   // gain, Q0.16 with room for one
  localparam int unsigned CW = 5;    // step counter

  // one quotient bit / one multiplier bit per cycle
  localparam logic [CW-1:0] LAST_STEP = 5'd16;

  localparam logic [DW-1:0] ME_RESET = 32'h0001_0000;  // 1.0
  localparam logic [GW-1:0] Q_ONE    = 17'h1_0000;     // 1.0 in Q0.16

  localparam logic [DW-1:0] S32_MAX = 32'h7FFF_FFFF;
  localparam logic [DW-1:0] S32_MIN = 32'h8000_0000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRIOR,
    ST_DIV,
    ST_MUL,
    ST_FIN
  } state_t;

endpackage

// ----- design/skf_if.sv -----
interface skf_in_if;
  logic                           valid;
  logic                           ready;
  logic signed [skf_pkg::DW-1:0]  measurement;
  logic                           start_new;

  modport source (output valid, measurement, start_new, input ready);
  modport sink   (input valid, measurement, start_new, output ready);
endinterface

interface skf_out_if;
  logic                           valid;
  logic                           ready;
  logic signed [skf_pkg::DW-1:0]  estimate;
  logic        [skf_pkg::DW-1:0]  error_estimate;
  logic        [skf_pkg::GW-1:0]  gain;
  logic                           div_zero;

  modport source (output valid, estimate, error_estimate, gain, div_zero, input ready);
  modport sink   (input valid, estimate, error_estimate, gain, div_zero, output ready);
endinterface

interface skf_cfg_if;
  logic                           valid;
  logic                           ready;
  logic        [skf_pkg::DW-1:0]  meas_error;

  modport source (output valid, meas_error, input ready);
  modport sink   (input valid, meas_error, output ready);
endinterface

// ----- design/scalar_kalman_filter.sv -----
// Channel | Dir | Payload                                          | Handshake
// --------+-----+--------------------------------------------------+-----------
// in_s    | in  | measurement (s Q16.16), start_new                | valid/ready
// out_s   | out | estimate, error_estimate, gain (Q0.16), div_zero | valid/ready
// cfg_s   | in  | meas_error (u Q16.16)                            | valid/ready
//
// Steps per item: accept, prior, 17 divide steps (one quotient bit each),
//   17 multiply steps (one gain bit each, both products side by side), finish.
// Reset: rst_n synchronous, active low; meas_error back to 1.0, next item
//   takes the initial prior. No clearing pass.
// Stalls: a result waits in the output register; the next item is accepted
//   meanwhile and runs up to the finish step, where it waits for a free slot.
// cfg_s is always ready; write it only while idle.

module scalar_kalman_filter (
  input  logic       clk,
  input  logic       rst_n,
  skf_in_if.sink     in_s,
  skf_out_if.source  out_s,
  skf_cfg_if.sink    cfg_s
);

  skf_pkg::state_t state_r, state_nxt;
  logic [skf_pkg::CW-1:0] cnt_r, cnt_nxt;

  logic [31:0] me_r, me_nxt;          // measurement error variance
  logic [31:0] meas_r, meas_nxt;      // held measurement
  logic        start_r, start_nxt;
  logic        primed_r, primed_nxt;
  logic [31:0] est_r, est_nxt;        // kept estimate (signed)
  logic [31:0] err_r, err_nxt;        // kept error

  logic [31:0] p_r, p_nxt;            // prior error
  logic [31:0] v_r, v_nxt;            // prior estimate (signed)
  logic [32:0] den_r, den_nxt;        // P + meas_error
  logic [33:0] rem_r, rem_nxt;        // partial remainder
  logic        dz_r, dz_nxt;
  logic [16:0] gain_r, gain_nxt;
  logic [16:0] mg_r, mg_nxt;          // gain, shifted out LSB first
  logic [16:0] mh_r, mh_nxt;          // 1 - gain, shifted out LSB first
  logic [32:0] diff_r, diff_nxt;      // measurement - prior (signed)
  logic [34:0] acc1_r, acc1_nxt;      // gain * diff / 2^16 (signed)
  logic [33:0] acc2_r, acc2_nxt;      // (1 - gain) * P / 2^16

  logic        ov_r, ov_nxt;
  logic [31:0] o_est_r, o_est_nxt;
  logic [31:0] o_err_r, o_err_nxt;
  logic [16:0] o_gain_r, o_gain_nxt;
  logic        o_dz_r, o_dz_nxt;

  // comb temporaries
  logic [35:0] pre_v;
  logic [33:0] trial;
  logic        ge;
  logic [16:0] g_fin;
  logic [34:0] add1;
  logic [33:0] add2;
  logic [35:0] sum_est;
  logic        in_fire;

  function automatic logic [31:0] sat36(input logic [35:0] x);
    if (!x[35] && (x[34:31] != 4'h0)) begin
      return skf_pkg::S32_MAX;
    end else if (x[35] && (x[34:31] != 4'hF)) begin
      return skf_pkg::S32_MIN;
    end
    return x[31:0];
  endfunction

  assign in_s.ready  = (state_r == skf_pkg::ST_IDLE);
  assign cfg_s.ready = 1'b1;
  assign in_fire     = in_s.valid && in_s.ready;

  assign out_s.valid          = ov_r;
  assign out_s.estimate       = o_est_r;
  assign out_s.error_estimate = o_err_r;
  assign out_s.gain           = o_gain_r;
  assign out_s.div_zero       = o_dz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= skf_pkg::ST_IDLE;
      cnt_r    <= '0;
      me_r     <= skf_pkg::ME_RESET;
      primed_r <= 1'b0;
      est_r    <= '0;
      err_r    <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      me_r     <= me_nxt;
      primed_r <= primed_nxt;
      est_r    <= est_nxt;
      err_r    <= err_nxt;
      ov_r     <= ov_nxt;
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    meas_r   <= meas_nxt;
    start_r  <= start_nxt;
    p_r      <= p_nxt;
    v_r      <= v_nxt;
    den_r    <= den_nxt;
    rem_r    <= rem_nxt;
    dz_r     <= dz_nxt;
    gain_r   <= gain_nxt;
    mg_r     <= mg_nxt;
    mh_r     <= mh_nxt;
    diff_r   <= diff_nxt;
    acc1_r   <= acc1_nxt;
    acc2_r   <= acc2_nxt;
    o_est_r  <= o_est_nxt;
    o_err_r  <= o_err_nxt;
    o_gain_r <= o_gain_nxt;
    o_dz_r   <= o_dz_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    me_nxt     = me_r;
    meas_nxt   = meas_r;
    start_nxt  = start_r;
    primed_nxt = primed_r;
    est_nxt    = est_r;
    err_nxt    = err_r;
    p_nxt      = p_r;
    v_nxt      = v_r;
    den_nxt    = den_r;
    rem_nxt    = rem_r;
    dz_nxt     = dz_r;
    gain_nxt   = gain_r;
    mg_nxt     = mg_r;
    mh_nxt     = mh_r;
    diff_nxt   = diff_r;
    acc1_nxt   = acc1_r;
    acc2_nxt   = acc2_r;
    ov_nxt     = ov_r && !out_s.ready;
    o_est_nxt  = o_est_r;
    o_err_nxt  = o_err_r;
    o_gain_nxt = o_gain_r;
    o_dz_nxt   = o_dz_r;

    pre_v   = {{4{meas_r[31]}}, meas_r} - {4'h0, me_r};
    trial   = (cnt_r == '0) ? rem_r : {rem_r[32:0], 1'b0};
    ge      = (trial >= {1'b0, den_r});
    g_fin   = dz_r ? '0 : {gain_r[15:0], ge};
    add1    = acc1_r + (mg_r[0] ? {{2{diff_r[32]}}, diff_r} : 35'd0);
    add2    = acc2_r + (mh_r[0] ? {2'b00, p_r} : 34'd0);
    sum_est = {{4{v_r[31]}}, v_r} + {acc1_r[34], acc1_r};

    if (cfg_s.valid) begin
      me_nxt = cfg_s.meas_error;
    end

    case (state_r)
      skf_pkg::ST_IDLE: begin
        if (in_fire) begin
          meas_nxt  = in_s.measurement;
          start_nxt = in_s.start_new;
          state_nxt = skf_pkg::ST_PRIOR;
        end
      end

      skf_pkg::ST_PRIOR: begin
        // fresh sequence: P = R/2, V = z - R (saturated)
        if (start_r || !primed_r) begin
          p_nxt = {1'b0, me_r[31:1]};
          v_nxt = sat36(pre_v);
        end else begin
          p_nxt = err_r;
          v_nxt = est_r;
        end
        den_nxt   = {1'b0, p_nxt} + {1'b0, me_r};
        dz_nxt    = (den_nxt == '0);
        rem_nxt   = {2'b00, p_nxt};
        cnt_nxt   = '0;
        state_nxt = skf_pkg::ST_DIV;
      end

      skf_pkg::ST_DIV: begin
        // restoring divide, quotient MSB first; first step is unshifted
        rem_nxt  = ge ? (trial - {1'b0, den_r}) : trial;
        gain_nxt = {gain_r[15:0], ge};
        if (cnt_r == '0) begin
          diff_nxt = {meas_r[31], meas_r} - {v_r[31], v_r};
        end
        if (cnt_r == skf_pkg::LAST_STEP) begin
          gain_nxt  = g_fin;
          mg_nxt    = g_fin;
          mh_nxt    = skf_pkg::Q_ONE - g_fin;
          acc1_nxt  = '0;
          acc2_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = skf_pkg::ST_MUL;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      skf_pkg::ST_MUL: begin
        // shift-right accumulate: keeps floor(product / 2^16) exact
        mg_nxt = {1'b0, mg_r[16:1]};
        mh_nxt = {1'b0, mh_r[16:1]};
        if (cnt_r == skf_pkg::LAST_STEP) begin
          acc1_nxt  = add1;
          acc2_nxt  = add2;
          cnt_nxt   = '0;
          state_nxt = skf_pkg::ST_FIN;
        end else begin
          acc1_nxt = {add1[34], add1[34:1]};
          acc2_nxt = {1'b0, add2[33:1]};
          cnt_nxt  = cnt_r + 1'b1;
        end
      end

      skf_pkg::ST_FIN: begin
        if (!ov_r || out_s.ready) begin
          est_nxt    = sat36(sum_est);
          err_nxt    = acc2_r[31:0];
          primed_nxt = 1'b1;
          ov_nxt     = 1'b1;
          o_est_nxt  = est_nxt;
          o_err_nxt  = err_nxt;
          o_gain_nxt = gain_r;
          o_dz_nxt   = dz_r;
          state_nxt  = skf_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = skf_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef SYNTH
  a_accept_to_prior: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == skf_pkg::ST_PRIOR))
    else $error("accepted item did not move to prior step");

  a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> (o_gain_r <= skf_pkg::Q_ONE))
    else $error("gain above one");

  a_dz_gain: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && o_dz_r) |-> (o_gain_r == '0))
    else $error("zero denominator with nonzero gain");

  a_err_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == skf_pkg::ST_FIN) |-> (acc2_r <= {2'b00, p_r}))
    else $error("error estimate above prior error");
`endif

endmodule
